// ===== src/rnsd_pkg.sv =====
// Shared types, constants and segment glyph lookup for the radix number segment display.
`default_nettype none
package rnsd_pkg;

	localparam int DIGIT_COUNT = 4;
	localparam int NIB_W       = 4;
	localparam int SEG_W       = 7;
	localparam int OUT_W       = 8;
	localparam int DEC_W       = 14;

	// Range limits for the number modes
	localparam logic [31:0] DEC_LIMIT = 32'd10000;
	localparam logic [31:0] BIN_LIMIT = 32'd16;
	localparam logic [31:0] OCT_LIMIT = 32'd4096;

	// Fixed glyphs for the error pattern
	localparam logic [SEG_W-1:0] GLYPH_BLANK = 7'h00;
	localparam logic [SEG_W-1:0] GLYPH_E     = 7'h79;
	localparam logic [SEG_W-1:0] GLYPH_R     = 7'h50;

	typedef enum logic [2:0] {
		OP_DEC     = 3'd0,
		OP_BIN     = 3'd1,
		OP_HEX     = 3'd2,
		OP_OCT     = 3'd3,
		OP_SET_DOT = 3'd4,
		OP_CLR_DOT = 3'd5
	} op_t;

	typedef logic [DIGIT_COUNT-1:0][NIB_W-1:0] nib_vec_t;

	// Decoded action for one transaction
	typedef struct packed {
		logic     show;     // load the four digits from nib
		logic     err;      // put up the error pattern
		logic     dot_wr;   // write one decimal point
		logic     dot_val;  // value for that point
		logic [1:0] dot_idx;
		nib_vec_t nib;      // index 0 is the leftmost digit
	} action_t;

	// Segment glyph for one hex digit, segments a-g in bits 0-6
	function automatic logic [SEG_W-1:0] glyph(input logic [NIB_W-1:0] n);
		logic [SEG_W-1:0] g;
		case (n)
			4'h0: g = 7'h3F;
			4'h1: g = 7'h06;
			4'h2: g = 7'h5B;
			4'h3: g = 7'h4F;
			4'h4: g = 7'h66;
			4'h5: g = 7'h6D;
			4'h6: g = 7'h7D;
			4'h7: g = 7'h07;
			4'h8: g = 7'h7F;
			4'h9: g = 7'h6F;
			4'hA: g = 7'h77;
			4'hB: g = 7'h7C;
			4'hC: g = 7'h39;
			4'hD: g = 7'h5E;
			4'hE: g = 7'h79;
			default: g = 7'h71;
		endcase
		return g;
	endfunction

	// One decimal digit of v at weight w: parallel threshold compares, v < 10*w
	function automatic logic [NIB_W-1:0] dec_digit(input logic [DEC_W-1:0] v,
			input logic [DEC_W-1:0] w);
		logic [NIB_W-1:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (v >= DEC_W'(k) * w) begin
				d = NIB_W'(k);
			end
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== src/radix_number_segment_display.sv =====
// Top level of the radix number segment display: input register, display state, result register.
//
// Usage:
//   Item channel (item_valid/item_ready) carries operation, number and digit_position.
//   Result channel (result_valid/result_ready) carries the four digit segment bytes
//   (bits 0-6 segments a-g, bit 7 decimal point, digit 1 leftmost) and error_shown.
//   Every transaction on the item channel yields exactly one result transaction,
//   in order, showing the whole display as it stands after that item.
// Pipeline: one input register and one result register, with the decode, split and glyph
//   lookup between them; result_valid rises when an item moves into the result register.
// Throughput: one item per cycle sustained while result_ready stays high.
// Stalls: when result_ready is low the held result stays put, the item register
//   keeps its item and item_ready drops; item_ready is high whenever the item
//   register is empty or about to move into the result register.
// Reset (arst_n low, asynchronous): both channels empty, all digits blank and
//   all decimal points cleared.
`default_nettype none
module radix_number_segment_display (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [31:0] number,
	input  wire logic [2:0]  digit_position,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       segments_digit1,
	output logic [7:0]       segments_digit2,
	output logic [7:0]       segments_digit3,
	output logic [7:0]       segments_digit4,
	output logic             error_shown
);
	import rnsd_pkg::*;

	// Input register
	logic        valid_s1;
	logic [2:0]  operation_s1;
	logic [31:0] number_s1;
	logic [2:0]  position_s1;

	// Display state
	logic [DIGIT_COUNT-1:0][SEG_W-1:0] seg_q;
	logic [DIGIT_COUNT-1:0]            point_q;
	logic [DIGIT_COUNT-1:0][SEG_W-1:0] seg_next;
	logic [DIGIT_COUNT-1:0]            point_next;

	// Result register
	logic                              result_valid_q;
	logic [DIGIT_COUNT-1:0][OUT_W-1:0] out_q;
	logic                              err_q;

	action_t act;
	logic    res_free;
	logic    take_s1;

	assign res_free   = !result_valid_q || result_ready;
	assign take_s1    = valid_s1 && res_free;
	assign item_ready = !valid_s1 || res_free;

	rnsd_decode u_decode (
		.operation      (operation_s1),
		.number         (number_s1),
		.digit_position (position_s1),
		.act            (act)
	);

	// Next display contents for the item in the input register
	always_comb begin
		seg_next   = seg_q;
		point_next = point_q;
		if (act.show) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				seg_next[i] = glyph(act.nib[i]);
			end
		end
		if (act.err) begin
			seg_next[0] = GLYPH_BLANK;
			seg_next[1] = GLYPH_E;
			seg_next[2] = GLYPH_R;
			seg_next[3] = GLYPH_R;
			point_next  = '0;
		end
		if (act.dot_wr) begin
			point_next[act.dot_idx] = act.dot_val;
		end
	end

	// Input register and its valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			operation_s1 <= operation;
			number_s1    <= number;
			position_s1  <= digit_position;
		end
	end

	// Display state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q          <= '0;
			point_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				seg_q          <= seg_next;
				point_q        <= point_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take_s1) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				out_q[i] <= {point_next[i], seg_next[i]};
			end
			err_q <= act.err;
		end
	end

	assign result_valid    = result_valid_q;
	assign segments_digit1 = out_q[0];
	assign segments_digit2 = out_q[1];
	assign segments_digit3 = out_q[2];
	assign segments_digit4 = out_q[3];
	assign error_shown     = err_q;

endmodule
`default_nettype wire

// ===== src/rnsd_decode.sv =====
// Combinational decode of one transaction into digit values and display actions.
`default_nettype none
module rnsd_decode (
	input  wire logic [2:0]        operation,
	input  wire logic [31:0]       number,
	input  wire logic [2:0]        digit_position,
	output rnsd_pkg::action_t      act
);
	import rnsd_pkg::*;

	logic [DEC_W-1:0] v;
	logic [DEC_W-1:0] rem_th;
	logic [DEC_W-1:0] rem_hu;
	logic [DEC_W-1:0] rem_te;
	logic [NIB_W-1:0] d_th;
	logic [NIB_W-1:0] d_hu;
	logic [NIB_W-1:0] d_te;
	nib_vec_t         nib_dec;
	nib_vec_t         nib_bin;
	nib_vec_t         nib_hex;
	nib_vec_t         nib_oct;
	logic             pos_ok;

	// Decimal split: thousands, hundreds, tens, units by compare and subtract
	assign v      = number[DEC_W-1:0];
	assign d_th   = dec_digit(v, DEC_W'(1000));
	assign rem_th = v - DEC_W'(d_th) * DEC_W'(1000);
	assign d_hu   = dec_digit(rem_th, DEC_W'(100));
	assign rem_hu = rem_th - DEC_W'(d_hu) * DEC_W'(100);
	assign d_te   = dec_digit(rem_hu, DEC_W'(10));
	assign rem_te = rem_hu - DEC_W'(d_te) * DEC_W'(10);

	// Fixed radix splits, leftmost digit at index 0
	always_comb begin
		nib_dec[0] = d_th;
		nib_dec[1] = d_hu;
		nib_dec[2] = d_te;
		nib_dec[3] = rem_te[NIB_W-1:0];
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			nib_bin[i] = {3'b000, number[3-i]};
			nib_hex[i] = number[15-4*i -: 4];
			nib_oct[i] = {1'b0, number[11-3*i -: 3]};
		end
	end

	assign pos_ok = (digit_position >= 3'd1) && (digit_position <= 3'(DIGIT_COUNT));

	// Action select
	always_comb begin
		act         = '0;
		act.dot_val = (op_t'(operation) == OP_SET_DOT);
		act.dot_idx = 2'(digit_position - 3'd1);
		unique case (op_t'(operation)) inside
			OP_DEC: begin
				act.nib  = nib_dec;
				act.show = (number < DEC_LIMIT);
				act.err  = !(number < DEC_LIMIT);
			end
			OP_BIN: begin
				act.nib  = nib_bin;
				act.show = (number < BIN_LIMIT);
				act.err  = !(number < BIN_LIMIT);
			end
			OP_HEX: begin
				act.nib  = nib_hex;
				act.show = 1'b1;
			end
			OP_OCT: begin
				act.nib  = nib_oct;
				act.show = (number < OCT_LIMIT);
				act.err  = !(number < OCT_LIMIT);
			end
			OP_SET_DOT, OP_CLR_DOT: begin
				act.dot_wr = pos_ok;
			end
			default: begin
				act.err = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== bench/radix_number_segment_display_tb.sv =====
// Self-checking testbench for the radix number segment display, with a display-tracking scoreboard.
`timescale 1ns / 100ps

// Segment patterns for hex digits, index 15 first; bits 0-6 are segments a-g
localparam logic [15:0][6:0] DIGIT_GLYPHS = {
	7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
	7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
};

// Whole display as one result shows it
typedef struct {
	logic [7:0] digit [4];
	logic       err;
} frame_t;

// Tracks the display contents and holds the frames still to come out of the block
class display_tracker;
	logic [6:0] glyphs [4];
	logic       points [4];
	frame_t     frames_due [$];
	int         mismatches;

	function new();
		for (int i = 0; i < rnsd_pkg::DIGIT_COUNT; i++) begin
			glyphs[i] = rnsd_pkg::GLYPH_BLANK;
			points[i] = 1'b0;
		end
		mismatches = 0;
	endfunction

	function int pending();
		return frames_due.size();
	endfunction

	// Work out the display after one accepted command and queue it
	function void note_command(input logic [2:0] op, input logic [31:0] num,
			input logic [2:0] pos);
		logic [3:0] nib [4];
		logic       load;
		logic       err;
		frame_t     frame;
		load = 1'b0;
		err  = 1'b0;
		case (op)
			rnsd_pkg::OP_DEC: begin
				if (num < rnsd_pkg::DEC_LIMIT) begin
					nib[0] = 4'(num / 1000);
					nib[1] = 4'((num / 100) % 10);
					nib[2] = 4'((num / 10) % 10);
					nib[3] = 4'(num % 10);
					load = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			rnsd_pkg::OP_BIN: begin
				if (num < rnsd_pkg::BIN_LIMIT) begin
					for (int i = 0; i < 4; i++) nib[i] = {3'b000, num[3-i]};
					load = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			rnsd_pkg::OP_HEX: begin
				for (int i = 0; i < 4; i++) nib[i] = num[15-4*i -: 4];
				load = 1'b1;
			end
			rnsd_pkg::OP_OCT: begin
				if (num < rnsd_pkg::OCT_LIMIT) begin
					for (int i = 0; i < 4; i++) nib[i] = {1'b0, num[11-3*i -: 3]};
					load = 1'b1;
				end else begin
					err = 1'b1;
				end
			end
			rnsd_pkg::OP_SET_DOT, rnsd_pkg::OP_CLR_DOT: begin
				// positions outside 1..4 leave everything as it is
				if (pos >= 3'd1 && pos <= 3'd4)
					points[2'(pos - 3'd1)] = (op == rnsd_pkg::OP_SET_DOT);
			end
			default: err = 1'b1;
		endcase

		if (load) begin
			for (int i = 0; i < 4; i++) glyphs[i] = DIGIT_GLYPHS[nib[i]];
		end
		// error pattern: blank E r r, all points off
		if (err) begin
			glyphs[0] = rnsd_pkg::GLYPH_BLANK;
			glyphs[1] = rnsd_pkg::GLYPH_E;
			glyphs[2] = rnsd_pkg::GLYPH_R;
			glyphs[3] = rnsd_pkg::GLYPH_R;
			for (int i = 0; i < 4; i++) points[i] = 1'b0;
		end

		for (int i = 0; i < 4; i++) frame.digit[i] = {points[i], glyphs[i]};
		frame.err = err;
		frames_due.push_back(frame);
	endfunction

	// Compare one accepted result with the oldest frame due
	function void check_display(input logic [7:0] d1, input logic [7:0] d2,
			input logic [7:0] d3, input logic [7:0] d4, input logic e);
		frame_t     want;
		logic [7:0] got [4];
		if (frames_due.size() == 0) begin
			$error("result transaction with no command outstanding");
			mismatches++;
			return;
		end
		want = frames_due.pop_front();
		got[0] = d1;
		got[1] = d2;
		got[2] = d3;
		got[3] = d4;
		for (int i = 0; i < 4; i++) begin
			if (got[i] !== want.digit[i]) begin
				$error("segments_digit%0d: expected %02h, actual %02h",
					i + 1, want.digit[i], got[i]);
				mismatches++;
			end
		end
		if (e !== want.err) begin
			$error("error_shown: expected %0b, actual %0b", want.err, e);
			mismatches++;
		end
	endfunction
endclass

module radix_number_segment_display_tb;
	import rnsd_pkg::*;

	// operation codes with no defined meaning; the block shows the error pattern
	localparam logic [2:0] OP_UNDEF_6 = 3'd6;
	localparam logic [2:0] OP_UNDEF_7 = 3'd7;

	localparam int PHASE_ITEMS  = 400;
	localparam int SURGE_ITEMS  = 50;
	localparam int HOLD_CYCLES  = 250;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        item_valid     = 1'b0;
	logic [2:0]  operation      = '0;
	logic [31:0] number         = '0;
	logic [2:0]  digit_position = '0;
	logic        result_ready   = 1'b0;
	wire         item_ready;
	wire         result_valid;
	wire  [7:0]  segments_digit1;
	wire  [7:0]  segments_digit2;
	wire  [7:0]  segments_digit3;
	wire  [7:0]  segments_digit4;
	wire         error_shown;

	display_tracker tracker = new();

	int tx_idle_pct   = 0;
	int rx_idle_pct   = 0;
	int hold_request  = 0;
	int quiet_cycles  = 0;

	always #5 clk = ~clk;

	radix_number_segment_display u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.operation       (operation),
		.number          (number),
		.digit_position  (digit_position),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.segments_digit1 (segments_digit1),
		.segments_digit2 (segments_digit2),
		.segments_digit3 (segments_digit3),
		.segments_digit4 (segments_digit4),
		.error_shown     (error_shown)
	);

	// Monitor: both channels sampled at the edge, quiet cycles counted for the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				tracker.note_command(operation, number, digit_position);
			if (result_valid && result_ready)
				tracker.check_display(segments_digit1, segments_digit2, segments_digit3,
					segments_digit4, error_shown);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Watchdog
	initial begin
		do @(posedge clk); while (quiet_cycles < STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Offer one command, with a random idle gap first; returns once accepted
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] num,
			input logic [2:0] pos);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid     <= 1'b1;
		operation      <= op;
		number         <= num;
		digit_position <= pos;
		do @(posedge clk); while (!item_ready);
	endtask

	// Mostly well-formed commands, some out of range, bad positions or undefined codes
	task automatic send_random_cmd();
		int          pick;
		logic [2:0]  op;
		logic [31:0] num;
		logic [2:0]  pos;
		pick = $urandom_range(99);
		num  = $urandom;
		pos  = 3'($urandom_range(7));
		if (pick < 22) begin
			op = OP_DEC;
			if ($urandom_range(9) < 8)      num = $urandom_range(9999);
			else if ($urandom_range(1) != 0) num = DEC_LIMIT + $urandom_range(3);
		end else if (pick < 34) begin
			op = OP_BIN;
			if ($urandom_range(9) < 8)      num = $urandom_range(15);
			else if ($urandom_range(1) != 0) num = BIN_LIMIT + $urandom_range(3);
		end else if (pick < 52) begin
			op = OP_HEX;
			if ($urandom_range(1) != 0)     num = $urandom_range(16'hFFFF);
		end else if (pick < 66) begin
			op = OP_OCT;
			if ($urandom_range(9) < 8)      num = $urandom_range(4095);
			else if ($urandom_range(1) != 0) num = OCT_LIMIT + $urandom_range(3);
		end else if (pick < 95) begin
			op = (pick < 81) ? OP_SET_DOT : OP_CLR_DOT;
			if ($urandom_range(9) < 8) pos = 3'($urandom_range(4, 1));
		end else begin
			op = ($urandom_range(1) != 0) ? OP_UNDEF_6 : OP_UNDEF_7;
		end
		send_cmd(op, num, pos);
	endtask

	task automatic wait_drained();
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, every operation, range edges, dots kept and cleared
		send_cmd(OP_HEX, 32'h0000_0000, 3'd0);
		send_cmd(OP_HEX, 32'hFFFF_FFFF, 3'd7);
		send_cmd(OP_HEX, 32'h1234_ABCD, 3'd0);
		send_cmd(OP_SET_DOT, 32'h0, 3'd1);
		send_cmd(OP_SET_DOT, 32'h0, 3'd2);
		send_cmd(OP_SET_DOT, 32'h0, 3'd3);
		send_cmd(OP_SET_DOT, 32'hFFFF_FFFF, 3'd4);
		send_cmd(OP_DEC, 32'd0, 3'd0);
		send_cmd(OP_DEC, 32'd9999, 3'd0);
		send_cmd(OP_CLR_DOT, 32'h0, 3'd3);
		send_cmd(OP_DEC, DEC_LIMIT, 3'd0);
		send_cmd(OP_SET_DOT, 32'h0, 3'd0);
		send_cmd(OP_SET_DOT, 32'h0, 3'd5);
		send_cmd(OP_CLR_DOT, 32'h0, 3'd7);
		send_cmd(OP_SET_DOT, 32'h0, 3'd2);
		send_cmd(OP_BIN, 32'd0, 3'd0);
		send_cmd(OP_BIN, 32'd15, 3'd0);
		send_cmd(OP_BIN, BIN_LIMIT, 3'd0);
		send_cmd(OP_SET_DOT, 32'h0, 3'd4);
		send_cmd(OP_OCT, 32'd0, 3'd0);
		send_cmd(OP_OCT, 32'd4095, 3'd0);
		send_cmd(OP_OCT, OCT_LIMIT, 3'd0);
		send_cmd(OP_UNDEF_6, 32'd5, 3'd1);
		send_cmd(OP_UNDEF_7, 32'hFFFF_FFFF, 3'd7);
		send_cmd(OP_DEC, 32'hFFFF_FFFF, 3'd0);

		// Random, back to back
		for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();

		// Receiver holds off long while commands keep coming, then sender waits for the lot
		hold_request = 1;
		for (int n = 0; n < SURGE_ITEMS; n++) send_random_cmd();
		item_valid <= 1'b0;
		wait_drained();
		@(posedge clk);

		// Sender idling
		tx_idle_pct = 45;
		for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();

		// Receiver stalling
		tx_idle_pct = 0;
		rx_idle_pct = 45;
		for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();

		// Both sides
		tx_idle_pct = 19;
		rx_idle_pct = 19;
		for (int n = 0; n < PHASE_ITEMS; n++) send_random_cmd();

		item_valid <= 1'b0;
		rx_idle_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

// ===== radix_number_segment_display.f =====
src/rnsd_pkg.sv
src/rnsd_decode.sv
src/radix_number_segment_display.sv
bench/radix_number_segment_display_tb.sv
